/* rtl/pms_pkg.sv */
// Shared types and constants of the PWM melody sequencer.
// Used by pms_ctrl, pms_datapath and the top level; depends on nothing.
package pms_pkg;

  localparam int PERIOD_W   = 26;
  localparam int MATCH_W    = 25;
  localparam int POS_W      = 7;
  localparam int FREQ_W     = 16;
  localparam int TEMPO_W    = 8;
  localparam int TICK_W     = 16;
  localparam int NOTES_W    = 8;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 64;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;
  localparam logic [TICK_W-1:0]   TICKS_MAX  = '1;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_MELODY_NOTES = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SLOW_MODE    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_ON    = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_STOP  = 2'd3
  } pms_op_t;

  typedef enum logic [1:0] {
    PH_PLAY = 2'd0,
    PH_GAP  = 2'd1,
    PH_NEXT = 2'd2,
    PH_OFF  = 2'd3
  } pms_phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_LOAD,
    S_DIV,
    S_PUSH
  } pms_state_t;

  typedef struct packed {
    logic latch;      // capture the input beat
    logic mem_wr;     // write the note entry
    logic start;      // restart playback from note 0
    logic tick;       // advance play/gap/off phases
    logic stop;       // stop timer, phase off
    logic set_play;   // next-note phase turns to play
    logic rest;       // loaded note is a rest
    logic div_start;  // launch period and length dividers
    logic load;       // commit divider results
    logic push;       // move state into the output register
  } pms_cmd_t;

  typedef struct packed {
    pms_op_t    op;
    pms_phase_t phase;
    logic       rest;
    logic       div_busy;
    logic       out_free;
  } pms_sts_t;

endpackage

/* rtl/pms_div.sv */
// Restoring divider, one quotient bit per cycle.
// Stand-alone; used by pms_datapath.
module pms_div #(
  parameter int NW = 26,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] dq_r, dq_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dvs_r;
  logic [DW:0]   part;
  logic [DW:0]   diff;

  // Partial remainder with the next dividend bit shifted in
  assign part = {rem_r, dq_r[NW-1]};
  assign diff = part - {1'b0, dvs_r};

  always_comb begin
    cnt_nxt = cnt_r;
    dq_nxt  = dq_r;
    rem_nxt = rem_r;
    if (start) begin
      cnt_nxt = CW'(NW);
      dq_nxt  = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (!diff[DW]) begin
        rem_nxt = diff[DW-1:0];
        dq_nxt  = {dq_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = part[DW-1:0];
        dq_nxt  = {dq_r[NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign busy     = (cnt_r != '0);
  assign quotient = dq_r;

endmodule

/* rtl/pms_ctrl.sv */
// Sequencing state machine of the melody sequencer.
// Depends on pms_pkg; drives pms_datapath through pms_cmd_t.
module pms_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  pms_pkg::pms_sts_t sts,
  output pms_pkg::pms_cmd_t cmd
);

  pms_pkg::pms_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pms_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      pms_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = pms_pkg::S_EXEC;
        end
      end
      pms_pkg::S_EXEC: begin
        unique case (sts.op)
          pms_pkg::OP_WRITE: begin
            cmd.mem_wr = 1'b1;
            state_nxt  = pms_pkg::S_PUSH;
          end
          pms_pkg::OP_START: begin
            cmd.start = 1'b1;
            state_nxt = pms_pkg::S_READ;
          end
          pms_pkg::OP_TICK: begin
            if (sts.phase == pms_pkg::PH_NEXT) begin
              cmd.set_play = 1'b1;
              state_nxt    = pms_pkg::S_READ;
            end else begin
              cmd.tick  = 1'b1;
              state_nxt = pms_pkg::S_PUSH;
            end
          end
          pms_pkg::OP_STOP: begin
            cmd.stop  = 1'b1;
            state_nxt = pms_pkg::S_PUSH;
          end
          default: state_nxt = pms_pkg::S_PUSH;
        endcase
      end
      pms_pkg::S_READ: state_nxt = pms_pkg::S_LOAD;
      pms_pkg::S_LOAD: begin
        if (sts.rest) begin
          cmd.rest  = 1'b1;
          state_nxt = pms_pkg::S_PUSH;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = pms_pkg::S_DIV;
        end
      end
      pms_pkg::S_DIV: begin
        if (!sts.div_busy) begin
          cmd.load  = 1'b1;
          state_nxt = pms_pkg::S_PUSH;
        end
      end
      pms_pkg::S_PUSH: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = pms_pkg::S_IDLE;
        end
      end
      default: state_nxt = pms_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_div_launch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pms_pkg::S_LOAD && !sts.rest) |=> sts.div_busy)
    else $error("dividers not running after launch");
`endif

endmodule

/* rtl/pms_datapath.sv */
// Note table, playback state, dividers and output register.
// Depends on pms_pkg and pms_div; commanded by pms_ctrl.
module pms_datapath #(
  parameter int MAX_NOTES = 128,
  parameter int CLOCK_HZ  = 50000000
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pms_pkg::pms_cmd_t                   cmd,
  output pms_pkg::pms_sts_t                   sts,
  input  logic [1:0]                          in_tuser,
  input  logic [pms_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic                                cfg_we,
  input  logic [pms_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [pms_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pms_pkg::OUT_DATA_W-1:0]      out_tdata
);

  localparam int MEM_DEPTH = (MAX_NOTES < 128) ? MAX_NOTES : 128;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int NW        = $clog2(CLOCK_HZ + 1);
  localparam int QW        = (NW > pms_pkg::PERIOD_W) ? NW : pms_pkg::PERIOD_W;
  localparam int ENTRY_W   = pms_pkg::FREQ_W + pms_pkg::TEMPO_W;

  // Captured input beat
  pms_pkg::pms_op_t                op_r;
  logic [pms_pkg::POS_W-1:0]       idx_r;
  logic [pms_pkg::FREQ_W-1:0]      freq_r;
  logic [pms_pkg::TEMPO_W-1:0]     tempo_r;

  // Configuration
  logic [pms_pkg::NOTES_W-1:0]     notes_r;
  logic                            slow_r;
  logic                            repeat_r;

  // Playback state
  pms_pkg::pms_phase_t             phase_r, phase_nxt;
  logic [pms_pkg::TICK_W-1:0]      tick_count_r, tick_count_nxt;
  logic [pms_pkg::TICK_W-1:0]      note_ticks_r, note_ticks_nxt;
  logic [pms_pkg::POS_W-1:0]       note_pos_r, note_pos_nxt;
  logic [pms_pkg::PERIOD_W-1:0]    period_r, period_nxt;
  logic [pms_pkg::MATCH_W-1:0]     match_r, match_nxt;
  logic                            timer_r, timer_nxt;

  logic [ENTRY_W-1:0]              mem [MEM_DEPTH];
  logic [ENTRY_W-1:0]              rd_r;
  logic [pms_pkg::FREQ_W-1:0]      rd_freq;
  logic [pms_pkg::TEMPO_W-1:0]     rd_tempo;
  logic                            wr_ok;

  logic                            per_busy, len_busy;
  logic [NW-1:0]                   per_q;
  logic [pms_pkg::FREQ_W-1:0]      len_q;
  logic [QW-1:0]                   per_qx;
  logic [pms_pkg::PERIOD_W-1:0]    period_ld;
  logic [pms_pkg::TICK_W-1:0]      ticks_ld;

  logic [pms_pkg::NOTES_W-1:0]     limit;
  logic [pms_pkg::NOTES_W-1:0]     pos_inc;
  logic                            tick_more;

  logic                            out_valid_r;
  logic [pms_pkg::OUT_DATA_W-1:0]  out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= pms_pkg::pms_op_t'(in_tuser);
      idx_r   <= in_tdata[6:0];
      freq_r  <= in_tdata[22:7];
      tempo_r <= in_tdata[30:23];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      notes_r  <= pms_pkg::NOTES_W'(1);
      slow_r   <= 1'b0;
      repeat_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pms_pkg::CFG_MELODY_NOTES: notes_r  <= cfg_wdata;
        pms_pkg::CFG_SLOW_MODE:    slow_r   <= cfg_wdata[0];
        pms_pkg::CFG_REPEAT_ON:    repeat_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Note table: one write port, one registered read at the current note
  assign wr_ok = (32'(idx_r) < MEM_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && wr_ok) begin
      mem[AW'(idx_r)] <= {tempo_r, freq_r};
    end
    rd_r <= mem[AW'(note_pos_r)];
  end

  assign rd_freq  = rd_r[pms_pkg::FREQ_W-1:0];
  assign rd_tempo = rd_r[ENTRY_W-1:pms_pkg::FREQ_W];

  pms_div #(.NW(NW), .DW(pms_pkg::FREQ_W)) u_div_per (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (NW'(CLOCK_HZ)),
    .divisor  (rd_freq),
    .busy     (per_busy),
    .quotient (per_q)
  );

  pms_div #(.NW(pms_pkg::FREQ_W), .DW(pms_pkg::TEMPO_W)) u_div_len (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rd_freq),
    .divisor  (rd_tempo),
    .busy     (len_busy),
    .quotient (len_q)
  );

  // Saturate the period; a zero tempo pins the length at its maximum
  assign per_qx    = QW'(per_q);
  assign period_ld = (per_qx > QW'(pms_pkg::PERIOD_MAX)) ? pms_pkg::PERIOD_MAX
                                                         : pms_pkg::PERIOD_W'(per_qx);
  assign ticks_ld  = (rd_tempo == '0) ? pms_pkg::TICKS_MAX : len_q;

  always_comb begin
    limit = (notes_r == '0) ? pms_pkg::NOTES_W'(1) : notes_r;
    if (limit > pms_pkg::NOTES_W'(MEM_DEPTH)) begin
      limit = pms_pkg::NOTES_W'(MEM_DEPTH);
    end
  end

  assign pos_inc   = {1'b0, note_pos_r} + 1'b1;
  assign tick_more = (tick_count_r < note_ticks_r);

  always_comb begin
    phase_nxt      = phase_r;
    tick_count_nxt = tick_count_r;
    note_ticks_nxt = note_ticks_r;
    note_pos_nxt   = note_pos_r;
    period_nxt     = period_r;
    match_nxt      = match_r;
    timer_nxt      = timer_r;
    if (cmd.start) begin
      tick_count_nxt = '0;
      note_pos_nxt   = '0;
      phase_nxt      = pms_pkg::PH_PLAY;
      timer_nxt      = 1'b1;
    end
    if (cmd.set_play) begin
      phase_nxt = pms_pkg::PH_PLAY;
    end
    if (cmd.rest) begin
      match_nxt = '0;
    end
    if (cmd.load) begin
      period_nxt     = period_ld;
      note_ticks_nxt = ticks_ld;
      match_nxt      = period_ld[pms_pkg::PERIOD_W-1:1];
    end
    if (cmd.stop) begin
      timer_nxt = 1'b0;
      phase_nxt = pms_pkg::PH_OFF;
    end
    if (cmd.tick) begin
      unique case (phase_r)
        pms_pkg::PH_PLAY, pms_pkg::PH_GAP: begin
          if (tick_more) begin
            tick_count_nxt = tick_count_r + 1'b1;
          end else begin
            tick_count_nxt = '0;
            if (phase_r == pms_pkg::PH_PLAY && slow_r) begin
              match_nxt = '0;
              phase_nxt = pms_pkg::PH_GAP;
            end else if (pos_inc >= limit) begin
              note_pos_nxt = '0;
              phase_nxt    = repeat_r ? pms_pkg::PH_NEXT : pms_pkg::PH_OFF;
            end else begin
              note_pos_nxt = pos_inc[pms_pkg::POS_W-1:0];
              phase_nxt    = pms_pkg::PH_NEXT;
            end
          end
        end
        pms_pkg::PH_OFF:  timer_nxt = 1'b0;
        pms_pkg::PH_NEXT: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= pms_pkg::PH_OFF;
      tick_count_r <= '0;
      note_ticks_r <= '0;
      note_pos_r   <= '0;
      period_r     <= '0;
      match_r      <= '0;
      timer_r      <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      tick_count_r <= tick_count_nxt;
      note_ticks_r <= note_ticks_nxt;
      note_pos_r   <= note_pos_nxt;
      period_r     <= period_nxt;
      match_r      <= match_nxt;
      timer_r      <= timer_nxt;
    end
  end

  // Output register: a pushed beat replaces one that leaves in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data_r <= {3'b000, note_pos_r, phase_r, timer_r, match_r, period_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sts.op       = op_r;
  assign sts.phase    = phase_r;
  assign sts.rest     = (rd_freq == '0);
  assign sts.div_busy = per_busy | len_busy;
  assign sts.out_free = !out_valid_r || out_tready;

`ifndef SYNTHESIS
  a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tick_count_r <= note_ticks_r)
    else $error("tick count passed note length");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, note_pos_r} < pms_pkg::NOTES_W'(MEM_DEPTH)))
    else $error("note position outside table");
`endif

endmodule

/* rtl/pwm_melody_sequencer.sv */
// PWM melody sequencer: command stream in, tone timer settings out.
// Depends on pms_pkg, pms_ctrl, pms_datapath and pms_div.
//
// Usage:
//   Input beats carry an op in in_tuser (write entry, start, tick, stop) and
//   the note entry fields in in_tdata. Every accepted beat yields exactly one
//   output beat holding the timer period, duty match, timer enable, play
//   phase and note position as they stand after the op.
//   The cfg_ port sets melody length, slow mode and repeat; write it only
//   while no beat is in flight.
// Processing:
//   Write, stop and plain ticks go from decode straight to the push state.
//   Start and the tick that loads the next note read the note table, then run
//   the period divider (CLOCK_HZ/freq) and the length divider (freq/tempo)
//   side by side, one quotient bit per cycle. A rest skips the dividers. One
//   beat is worked on at a time; the period divider, with a quotient of
//   $clog2(CLOCK_HZ+1) bits (26 at 50 MHz), sets the worst case.
// Reset: phase off, timer stopped, all counters and timer values zero,
//   melody length 1. The note table is not cleared.
// Stall: the output register holds its beat while out_tready is low; the
//   next input beat is still taken and worked on, then waits to be pushed.
module pwm_melody_sequencer #(
  parameter int MAX_NOTES = 128,
  parameter int CLOCK_HZ  = 50000000
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: entry_index[6:0], entry_freq[22:7], entry_tempo[30:23], zero[31]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [pms_pkg::IN_DATA_W-1:0]      in_tdata,
  // in_tuser: op[1:0]
  input  logic [1:0]                         in_tuser,
  // out_tdata: pwm_period[25:0], pwm_match[50:26], tone_enable[51],
  //            play_phase[53:52], note_position[60:54], zero[63:61]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pms_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_we,
  input  logic [pms_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [pms_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  pms_pkg::pms_cmd_t cmd;
  pms_pkg::pms_sts_t sts;

  // Sequencing: accept, decode, table read, divide, push
  pms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage, playback state and arithmetic
  pms_datapath #(
    .MAX_NOTES (MAX_NOTES),
    .CLOCK_HZ  (CLOCK_HZ)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* test/tb_pwm_melody_sequencer.sv */
// Self-checking testbench for pwm_melody_sequencer: a directed table of beats,
// then random melodies, checked against typed results or an in-bench predictor.
// Depends on rtl/pms_pkg.sv and rtl/pwm_melody_sequencer.sv.
module tb_pwm_melody_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TONE_CLK_HZ   = 50_000_000;
  localparam int          NOTE_SLOTS    = 128;
  // Longest beat in flight: table read plus both dividers, with margin.
  localparam int          SETTLE_CYCLES = 48;
  localparam int          RANDOM_BEATS  = 1200;

  // One output beat, laid out exactly as out_tdata (lowest field last).
  typedef struct packed {
    logic [2:0]                   pad;
    logic [pms_pkg::POS_W-1:0]    pos;
    pms_pkg::pms_phase_t          ph;
    logic                         en;
    logic [pms_pkg::MATCH_W-1:0]  match_v;
    logic [pms_pkg::PERIOD_W-1:0] period;
  } tone_beat_t;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                      kind;
    pms_pkg::pms_op_t               op;
    logic [pms_pkg::POS_W-1:0]      idx;
    logic [pms_pkg::FREQ_W-1:0]     freq;
    logic [pms_pkg::TEMPO_W-1:0]    tempo;
    logic                           typed;
    tone_beat_t                     want;
    logic [pms_pkg::CFG_ADDR_W-1:0] addr;
    logic [pms_pkg::CFG_DATA_W-1:0] data;
  } dir_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [pms_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]                     in_tuser = pms_pkg::OP_WRITE;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [pms_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_we = 1'b0;
  logic [pms_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [pms_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  pwm_melody_sequencer #(
    .MAX_NOTES (NOTE_SLOTS),
    .CLOCK_HZ  (TONE_CLK_HZ)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Tone predictor: shadow copy of note table, play state and settings.
  // ---------------------------------------------------------------------------
  logic [pms_pkg::FREQ_W-1:0]   freq_mem  [NOTE_SLOTS];
  logic [pms_pkg::TEMPO_W-1:0]  tempo_mem [NOTE_SLOTS];
  bit                           written   [NOTE_SLOTS];
  pms_pkg::pms_phase_t          ph         = pms_pkg::PH_OFF;
  logic [pms_pkg::TICK_W-1:0]   tick_cnt   = '0;
  logic [pms_pkg::TICK_W-1:0]   note_len   = '0;
  logic [pms_pkg::POS_W-1:0]    pos        = '0;
  logic [pms_pkg::PERIOD_W-1:0] period     = '0;
  logic [pms_pkg::MATCH_W-1:0]  tone_match = '0;
  logic                         run        = 1'b0;
  logic [pms_pkg::NOTES_W-1:0]  notes_cfg  = 8'd1;
  logic                         slow_cfg   = 1'b0;
  logic                         loop_cfg   = 1'b0;

  tone_beat_t tone_q[$];   // predicted beats, oldest first
  dir_row_t   dir_q[$];    // directed stimulus table
  int         err_cnt = 0;
  int         burst_left = 0;

  // Melody length after clamping: 0 plays one note, anything above the table
  // size plays the whole table.
  function automatic int unsigned melody_len();
    int unsigned n;
    n = notes_cfg;
    if (n == 0) n = 1;
    if (n > NOTE_SLOTS) n = NOTE_SLOTS;
    return n;
  endfunction

  // A rest only silences the tone; period and length of the last note stay.
  function automatic void load_note(logic [pms_pkg::POS_W-1:0] p);
    int unsigned fq, tp, q;
    fq = freq_mem[p];
    tp = tempo_mem[p];
    if (fq != 0) begin
      q = TONE_CLK_HZ / fq;
      if (q > pms_pkg::PERIOD_MAX) q = pms_pkg::PERIOD_MAX;
      period     = q[pms_pkg::PERIOD_W-1:0];
      note_len   = (tp == 0) ? pms_pkg::TICKS_MAX : pms_pkg::TICK_W'(fq / tp);
      tone_match = period[pms_pkg::PERIOD_W-1:1];
    end else begin
      tone_match = '0;
    end
  endfunction

  // Step to the next note; past the end wrap to note 0, and drop to off
  // unless looping.
  function automatic void next_note();
    int unsigned nx;
    nx = pos + 1;
    ph = pms_pkg::PH_NEXT;
    if (nx >= melody_len()) begin
      nx = 0;
      if (!loop_cfg) ph = pms_pkg::PH_OFF;
    end
    pos = nx[pms_pkg::POS_W-1:0];
  endfunction

  function automatic void tick_note();
    case (ph)
      pms_pkg::PH_PLAY: begin
        if (tick_cnt < note_len) begin
          tick_cnt = tick_cnt + 1'b1;
        end else begin
          tick_cnt = '0;
          if (slow_cfg) begin
            tone_match = '0;
            ph         = pms_pkg::PH_GAP;
          end else begin
            next_note();
          end
        end
      end
      pms_pkg::PH_GAP: begin
        if (tick_cnt < note_len) begin
          tick_cnt = tick_cnt + 1'b1;
        end else begin
          tick_cnt = '0;
          next_note();
        end
      end
      pms_pkg::PH_NEXT: begin
        load_note(pos);
        ph = pms_pkg::PH_PLAY;
      end
      default: run = 1'b0;
    endcase
  endfunction

  // Apply one command beat to the shadow state; return the beat it yields.
  function automatic tone_beat_t apply_op(pms_pkg::pms_op_t op,
                                          logic [pms_pkg::POS_W-1:0] idx,
                                          logic [pms_pkg::FREQ_W-1:0] f,
                                          logic [pms_pkg::TEMPO_W-1:0] t);
    tone_beat_t r;
    case (op)
      pms_pkg::OP_WRITE: begin
        freq_mem[idx]  = f;
        tempo_mem[idx] = t;
        written[idx]   = 1'b1;
      end
      pms_pkg::OP_START: begin
        tick_cnt = '0;
        pos      = '0;
        load_note('0);
        ph  = pms_pkg::PH_PLAY;
        run = 1'b1;
      end
      pms_pkg::OP_TICK: tick_note();
      default: begin
        run = 1'b0;
        ph  = pms_pkg::PH_OFF;
      end
    endcase
    r         = '0;
    r.period  = period;
    r.match_v = tone_match;
    r.en      = run;
    r.ph      = ph;
    r.pos     = pos;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table builders.
  // ---------------------------------------------------------------------------
  function automatic void add_beat(pms_pkg::pms_op_t op, logic [pms_pkg::POS_W-1:0] idx,
                                   logic [pms_pkg::FREQ_W-1:0] f,
                                   logic [pms_pkg::TEMPO_W-1:0] t);
    dir_row_t row;
    row       = '0;
    row.kind  = ROW_BEAT;
    row.op    = op;
    row.idx   = idx;
    row.freq  = f;
    row.tempo = t;
    dir_q.push_back(row);
  endfunction

  // Beat whose result is plain to see: type the expectation in directly.
  function automatic void add_chk(pms_pkg::pms_op_t op, logic [pms_pkg::POS_W-1:0] idx,
                                  logic [pms_pkg::FREQ_W-1:0] f,
                                  logic [pms_pkg::TEMPO_W-1:0] t,
                                  logic [pms_pkg::PERIOD_W-1:0] p,
                                  logic [pms_pkg::MATCH_W-1:0] m,
                                  logic en, pms_pkg::pms_phase_t phz,
                                  logic [pms_pkg::POS_W-1:0] at);
    dir_row_t row;
    row              = '0;
    row.kind         = ROW_BEAT;
    row.op           = op;
    row.idx          = idx;
    row.freq         = f;
    row.tempo        = t;
    row.typed        = 1'b1;
    row.want.period  = p;
    row.want.match_v = m;
    row.want.en      = en;
    row.want.ph      = phz;
    row.want.pos     = at;
    dir_q.push_back(row);
  endfunction

  function automatic void add_cfg(logic [pms_pkg::CFG_ADDR_W-1:0] a,
                                  logic [pms_pkg::CFG_DATA_W-1:0] d);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.addr = a;
    row.data = d;
    dir_q.push_back(row);
  endfunction

  // Random note entry, {tempo, freq}. Most notes last a handful of ticks so
  // that melodies actually advance; rests, long notes and zero tempo are rare.
  function automatic logic [23:0] pick_note();
    int unsigned sel, fq, tp;
    sel = $urandom_range(0, 79);
    if (sel < 6) begin
      fq = 0;
      tp = $urandom_range(0, 255);
    end else if (sel < 8) begin
      fq = $urandom_range(1, 65535);
      tp = $urandom_range(200, 255);
    end else if (sel == 8) begin
      fq = $urandom_range(1, 65535);
      tp = 0;
    end else begin
      tp = $urandom_range(1, 255);
      fq = tp * $urandom_range(0, 5) + $urandom % tp;
    end
    return {tp[7:0], fq[15:0]};
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus tasks. All called right after a rising edge.
  // ---------------------------------------------------------------------------

  // Send one command beat. Work in bursts: hold valid high from beat to beat
  // within a burst, drop it for a random gap between bursts.
  task automatic push_beat(pms_pkg::pms_op_t op, logic [pms_pkg::POS_W-1:0] idx,
                           logic [pms_pkg::FREQ_W-1:0] f,
                           logic [pms_pkg::TEMPO_W-1:0] t, logic typed, tone_beat_t want);
    tone_beat_t calc;
    int         gap;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 50)
                                               : $urandom_range(1, 8);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, t, f, idx};
    do @(posedge clk); while (!in_tready);
    // Beat accepted at this edge: advance the predictor and queue its result.
    calc = apply_op(op, idx, f, t);
    tone_q.push_back(typed ? want : calc);
    burst_left--;
  endtask

  // Write one setting register, then wait with cfg_we low so back-to-back writes
  // never touch cfg_we twice in one step.
  task automatic write_reg(logic [pms_pkg::CFG_ADDR_W-1:0] a,
                           logic [pms_pkg::CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (a)
      pms_pkg::CFG_MELODY_NOTES: notes_cfg = d;
      pms_pkg::CFG_SLOW_MODE:    slow_cfg  = d[0];
      pms_pkg::CFG_REPEAT_ON:    loop_cfg  = d[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Hold off new beats until every predicted beat has come back, then let the
  // block finish any internal work before settings change.
  task automatic settle();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (tone_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall on a pattern that switches at random between modes
  // (always ready, alternate, mostly stalled, mostly ready).
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ~out_tready;
      2:       out_tready <= ($urandom_range(0, 9) < 3);
      default: out_tready <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare every accepted beat, field by field, with the
  // oldest prediction.
  // ---------------------------------------------------------------------------
  tone_beat_t seen, want_b;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen = out_tdata;
      if (tone_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("%0t: result beat with nothing pending: %h", $realtime,
                                    out_tdata);
      end else begin
        want_b = tone_q.pop_front();
        if (seen.period !== want_b.period || seen.match_v !== want_b.match_v ||
            seen.en !== want_b.en || seen.ph !== want_b.ph || seen.pos !== want_b.pos ||
            seen.pad !== want_b.pad) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: got period %0d match %0d en %b phase %0d pos %0d pad %b,",
                     $realtime, seen.period, seen.match_v, seen.en, seen.ph, seen.pos,
                     seen.pad, " want period %0d match %0d en %b phase %0d pos %0d",
                     want_b.period, want_b.match_v, want_b.en, want_b.ph, want_b.pos);
        end
      end
    end
  end

  // Guard against a hung handshake.
  initial begin
    #10ms;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned   sent, lim, n_ops, sel, ph_no;
    logic [23:0]   nt;
    logic [7:0]    notes_v;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Out of reset everything is zero and the tone is off.
    add_chk(pms_pkg::OP_STOP,  7'd0,   16'd0,     8'd0,
            26'd0, 25'd0, 1'b0, pms_pkg::PH_OFF, 7'd0);
    add_chk(pms_pkg::OP_TICK,  7'd0,   16'd0,     8'd0,
            26'd0, 25'd0, 1'b0, pms_pkg::PH_OFF, 7'd0);
    // Lowest frequency: longest period, length 1/255 = 0 ticks.
    add_chk(pms_pkg::OP_WRITE, 7'd0,   16'd1,     8'd255,
            26'd0, 25'd0, 1'b0, pms_pkg::PH_OFF, 7'd0);
    add_chk(pms_pkg::OP_START, 7'd0,   16'd0,     8'd0,
            26'd50_000_000, 25'd25_000_000, 1'b1, pms_pkg::PH_PLAY, 7'd0);
    // One-note melody without repeat ends: phase off while the timer still runs,
    add_chk(pms_pkg::OP_TICK,  7'd0,   16'd0,     8'd0,
            26'd50_000_000, 25'd25_000_000, 1'b1, pms_pkg::PH_OFF, 7'd0);
    // ... and the following tick stops the timer.
    add_chk(pms_pkg::OP_TICK,  7'd0,   16'd0,     8'd0,
            26'd50_000_000, 25'd25_000_000, 1'b0, pms_pkg::PH_OFF, 7'd0);
    add_chk(pms_pkg::OP_WRITE, 7'd127, 16'd65535, 8'd0,
            26'd50_000_000, 25'd25_000_000, 1'b0, pms_pkg::PH_OFF, 7'd0);
    // Rest as the first note of the melody.
    add_chk(pms_pkg::OP_WRITE, 7'd0,   16'd0,     8'd77,
            26'd50_000_000, 25'd25_000_000, 1'b0, pms_pkg::PH_OFF, 7'd0);
    add_beat(pms_pkg::OP_WRITE, 7'd1,  16'd3,     8'd2);
    // Zero tempo: length saturates.
    add_beat(pms_pkg::OP_WRITE, 7'd2,  16'd65535, 8'd0);
    add_cfg(pms_pkg::CFG_MELODY_NOTES, 8'd3);
    add_cfg(pms_pkg::CFG_SLOW_MODE,    8'd1);
    add_cfg(pms_pkg::CFG_REPEAT_ON,    8'd1);
    // Rest first: tone silenced, period and length of the last note kept.
    add_chk(pms_pkg::OP_START, 7'd0,   16'd0,     8'd0,
            26'd50_000_000, 25'd0, 1'b1, pms_pkg::PH_PLAY, 7'd0);
    // Walk play, gap and next through notes 0 and 1 into note 2.
    repeat (8) add_beat(pms_pkg::OP_TICK, 7'd0, 16'd0, 8'd0);
    // Edit a note while it plays, restart mid-note, then stop.
    add_beat(pms_pkg::OP_WRITE, 7'd2,  16'd100,   8'd100);
    add_beat(pms_pkg::OP_START, 7'd0,  16'd0,     8'd0);
    add_beat(pms_pkg::OP_STOP,  7'd0,  16'd0,     8'd0);

    foreach (dir_q[i]) begin
      if (dir_q[i].kind == ROW_CFG) begin
        if (i == 0 || dir_q[i-1].kind != ROW_CFG) settle();
        write_reg(dir_q[i].addr, dir_q[i].data);
      end else begin
        push_beat(dir_q[i].op, dir_q[i].idx, dir_q[i].freq, dir_q[i].tempo,
                  dir_q[i].typed, dir_q[i].want);
      end
    end

    // Random part: a run of melody phases. Each one settles, picks new
    // settings, makes sure every note the melody can reach is written,
    // starts playback and then mostly ticks, with edits, restarts and stops
    // mixed in. Every position the predictor can ever load lies below a
    // melody length in force when it was set, and all of those are written
    // before any start, so an unwritten entry is never read.
    sent  = 0;
    ph_no = 0;
    while (sent < RANDOM_BEATS) begin
      settle();
      case (ph_no)
        0:       notes_v = 8'd0;
        1:       notes_v = 8'd255;
        2:       notes_v = 8'd128;
        3:       notes_v = 8'd1;
        default: notes_v = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(2, 12));
      endcase
      write_reg(pms_pkg::CFG_MELODY_NOTES, notes_v);
      // Single-bit settings: mostly 0/1, sometimes a full random byte.
      write_reg(pms_pkg::CFG_SLOW_MODE, ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                : 8'($urandom_range(0, 1)));
      write_reg(pms_pkg::CFG_REPEAT_ON, ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                : 8'($urandom_range(0, 1)));
      lim = melody_len();

      // Fill every reachable slot not yet written, then rewrite a few.
      for (int i = 0; i < lim; i++) begin
        if (!written[i]) begin
          nt = pick_note();
          push_beat(pms_pkg::OP_WRITE, 7'(i), nt[15:0], nt[23:16], 1'b0, '0);
          sent++;
        end
      end
      repeat ($urandom_range(1, (lim < 6) ? lim : 6)) begin
        nt = pick_note();
        push_beat(pms_pkg::OP_WRITE, 7'($urandom_range(0, lim - 1)), nt[15:0], nt[23:16],
                  1'b0, '0);
        sent++;
      end

      push_beat(pms_pkg::OP_START, 7'($urandom), 16'($urandom), 8'($urandom), 1'b0, '0);
      sent++;

      n_ops = $urandom_range(60, 140);
      repeat (n_ops) begin
        sel = $urandom_range(0, 99);
        nt  = pick_note();
        if (sel < 78) begin
          push_beat(pms_pkg::OP_TICK, 7'($urandom), 16'($urandom), 8'($urandom),
                    1'b0, '0);
        end else if (sel < 88) begin
          // Any slot, in the melody or beyond it.
          push_beat(pms_pkg::OP_WRITE, 7'($urandom), nt[15:0], nt[23:16], 1'b0, '0);
        end else if (sel < 93) begin
          push_beat(pms_pkg::OP_START, 7'($urandom), 16'($urandom), 8'($urandom),
                    1'b0, '0);
        end else if (sel < 97) begin
          push_beat(pms_pkg::OP_STOP, 7'($urandom), 16'($urandom), 8'($urandom),
                    1'b0, '0);
        end else begin
          // Edit a note of the melody while it plays.
          push_beat(pms_pkg::OP_WRITE, 7'($urandom_range(0, lim - 1)), nt[15:0],
                    nt[23:16], 1'b0, '0);
        end
        sent++;
      end
      ph_no++;
    end

    // Drain: wait out every pending result, then the block's latency.
    settle();
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/pms_pkg.sv
rtl/pms_div.sv
rtl/pms_ctrl.sv
rtl/pms_datapath.sv
rtl/pwm_melody_sequencer.sv
test/tb_pwm_melody_sequencer.sv
